// File: hw/rtl/tawd_pkg.sv
`timescale 1ns / 1ps

package tawd_pkg;

  // Request kinds carried in req_type
  typedef enum logic [1:0] {
    REQ_LOOP_CHECK = 2'd0,
    REQ_TASK_ALIVE = 2'd1,
    REQ_PANIC      = 2'd2,
    REQ_RESERVED   = 2'd3
  } req_type_t;

  // Latched panic reasons; other values are external codes
  localparam logic [3:0] REASON_NONE         = 4'd0;
  localparam logic [3:0] REASON_LOOP_TIMEOUT = 4'd1;
  localparam logic [3:0] REASON_TASK_MISSED  = 4'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_LOOP_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_FEED_PERIOD = 2'd1;
  localparam logic [1:0] CFG_WDG_ENABLE  = 2'd2;

  localparam logic [31:0] LOOP_LIMIT_RST  = 32'd100;
  localparam logic [31:0] FEED_PERIOD_RST = 32'd100;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] tick_ms;
    logic [7:0]  task_id;
    logic [3:0]  panic_code;
  } in_t;

  typedef struct packed {
    logic       feed;
    logic [3:0] panic_reason;
  } out_t;

  // Supervisor state other than the alive bits
  typedef struct packed {
    logic [3:0]  reason;
    logic [31:0] last_check;
    logic [31:0] last_feed;
  } sup_state_t;

  // Programmed configuration
  typedef struct packed {
    logic [31:0] loop_limit;
    logic [31:0] feed_period;
    logic        wdg_enable;
  } cfg_t;

endpackage

// File: hw/rtl/tawd_eval.sv
`timescale 1ns / 1ps

module tawd_eval #(
  parameter int TASK_COUNT = 8
) (
  input  tawd_pkg::in_t        req,
  input  tawd_pkg::cfg_t       cfg,
  input  tawd_pkg::sup_state_t st,
  input  logic [TASK_COUNT-1:0] alive,
  output tawd_pkg::sup_state_t st_nxt,
  output logic [TASK_COUNT-1:0] alive_nxt,
  output tawd_pkg::out_t       res
);
  import tawd_pkg::*;

  logic [31:0]           since_check;
  logic [31:0]           since_feed;
  logic                  timeout;
  logic                  missed;
  logic                  feed_due;
  logic [TASK_COUNT-1:0] id_hot;

  // Elapsed times, modulo 2^32
  assign since_check = req.tick_ms - st.last_check;
  assign since_feed  = req.tick_ms - st.last_feed;
  assign timeout     = (st.last_check != 32'd0) && (since_check > cfg.loop_limit);
  assign missed      = (alive != {TASK_COUNT{1'b1}});
  assign feed_due    = (since_feed >= cfg.feed_period);

  // One-hot decode of the task id; ids past the task count decode to nothing
  always_comb begin
    for (int i = 0; i < TASK_COUNT; i++) begin
      id_hot[i] = (req.task_id == 8'(i));
    end
  end

  always_comb begin
    st_nxt    = st;
    alive_nxt = alive;
    res.feed  = 1'b0;
    case (req_type_t'(req.req_type))
      REQ_LOOP_CHECK: begin
        if (st.reason == REASON_NONE) begin
          if (timeout) begin
            st_nxt.reason = REASON_LOOP_TIMEOUT;
          end else begin
            st_nxt.last_check = req.tick_ms;
            if (missed) begin
              st_nxt.reason = REASON_TASK_MISSED;
            end else begin
              alive_nxt = '0;
              if (feed_due) begin
                st_nxt.last_feed = req.tick_ms;
                res.feed         = cfg.wdg_enable;
              end
            end
          end
        end
      end
      REQ_TASK_ALIVE: begin
        alive_nxt = alive | id_hot;
      end
      REQ_PANIC: begin
        if (st.reason == REASON_NONE) begin
          st_nxt.reason = req.panic_code;
        end
      end
      default: begin
      end
    endcase
    res.panic_reason = st_nxt.reason;
  end

endmodule

// File: hw/rtl/task_alive_watchdog_supervisor_core.sv
`timescale 1ns / 1ps

// Task liveness watchdog supervisor. Requests mark a task alive, raise a
// panic, or run a loop check with the current millisecond time; each request
// returns exactly one result carrying the feed pulse and the latched panic
// reason. A request is taken into an input register, evaluated against the
// supervisor state by combinational logic and written to a result register,
// so one request is accepted every cycle while in_stall is low and its
// result is held there while out_stall is high. The evaluation path
// (two 32-bit subtract-and-compare checks feeding the state update) sets the
// cycle. in_stall rises only while the input register holds a request that
// the stalled result register cannot take. Configuration writes are always
// ready and must be made while no request is in flight.
module task_alive_watchdog_supervisor_core #(
  parameter int TASK_COUNT = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  tawd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output tawd_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data
);
  import tawd_pkg::*;

  logic                  in_valid_r;
  in_t                   in_data_r;
  logic                  out_valid_r;
  out_t                  out_data_r;
  cfg_t                  cfg_r;
  sup_state_t            st_r;
  sup_state_t            st_nxt;
  logic [TASK_COUNT-1:0] alive_r;
  logic [TASK_COUNT-1:0] alive_nxt;
  out_t                  res;
  logic                  out_free;
  logic                  advance;

  // Handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.loop_limit  <= LOOP_LIMIT_RST;
      cfg_r.feed_period <= FEED_PERIOD_RST;
      cfg_r.wdg_enable  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOOP_LIMIT:  cfg_r.loop_limit  <= cfg_data;
        CFG_FEED_PERIOD: cfg_r.feed_period <= cfg_data;
        CFG_WDG_ENABLE:  cfg_r.wdg_enable  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Request evaluation
  tawd_eval #(
    .TASK_COUNT(TASK_COUNT)
  ) u_eval (
    .req       (in_data_r),
    .cfg       (cfg_r),
    .st        (st_r),
    .alive     (alive_r),
    .st_nxt    (st_nxt),
    .alive_nxt (alive_nxt),
    .res       (res)
  );

  // Supervisor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '0;
      alive_r <= '0;
    end else if (advance) begin
      st_r    <= st_nxt;
      alive_r <= alive_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  // A feed pulse never goes out alongside a latched panic
  a_feed_no_panic: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.feed |-> out_data_r.panic_reason == REASON_NONE)
    else $error("feed issued with a panic latched");

  // Once latched, the panic reason never changes
  a_reason_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.reason != REASON_NONE |=> st_r.reason == $past(st_r.reason))
    else $error("latched panic reason changed");

  // The state only moves when a request passes into the result register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(st_r) && $stable(alive_r))
    else $error("state changed without a request");

endmodule

// File: sim/task_alive_watchdog_supervisor_core_test.sv
`timescale 1ns / 1ps

import tawd_pkg::*;

// Predicts the supervisor's verdict for each accepted request and holds the
// verdicts still owed by the block.
class supervisor_scoreboard #(int TASKS = 8);
  logic [31:0] loop_limit;
  logic [31:0] feed_period;
  logic        wdg_enable;
  logic [3:0]  reason;
  logic [31:0] alive;
  logic [31:0] last_check;
  logic [31:0] last_feed;
  out_t        owed_verdicts[$];
  int          results_seen;
  int          errors;

  function new();
    loop_limit   = LOOP_LIMIT_RST;
    feed_period  = FEED_PERIOD_RST;
    wdg_enable   = 1'b0;
    reason       = REASON_NONE;
    alive        = '0;
    last_check   = '0;
    last_feed    = '0;
    results_seen = 0;
    errors       = 0;
  endfunction

  function void set_register(logic [1:0] idx, logic [31:0] val);
    case (idx)
      CFG_LOOP_LIMIT:  loop_limit = val;
      CFG_FEED_PERIOD: feed_period = val;
      CFG_WDG_ENABLE:  wdg_enable = val[0];
      default: ;
    endcase
  endfunction

  // Apply one request to the supervisor state and return its verdict
  function out_t supervise(in_t req);
    logic [31:0] mask;
    out_t        verdict;
    mask = (TASKS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << TASKS) - 32'd1);
    verdict.feed = 1'b0;
    case (req.req_type)
      REQ_LOOP_CHECK: begin
        // once latched, checks do nothing
        if (reason == REASON_NONE) begin
          if (last_check != 32'd0 && (req.tick_ms - last_check) > loop_limit) begin
            reason = REASON_LOOP_TIMEOUT;
          end else begin
            last_check = req.tick_ms;
            if ((alive & mask) != mask) begin
              reason = REASON_TASK_MISSED;
            end else begin
              alive = '0;
              // period passed: feed time moves on even when disabled
              if ((req.tick_ms - last_feed) >= feed_period) begin
                last_feed    = req.tick_ms;
                verdict.feed = wdg_enable;
              end
            end
          end
        end
      end
      REQ_TASK_ALIVE: begin
        if (req.task_id < TASKS) alive[req.task_id[4:0]] = 1'b1;
      end
      REQ_PANIC: begin
        if (reason == REASON_NONE) reason = req.panic_code;
      end
      default: ;
    endcase
    verdict.panic_reason = reason;
    return verdict;
  endfunction

  function void note_request(in_t req);
    owed_verdicts.push_back(supervise(req));
  endfunction

  function int verdicts_due();
    return owed_verdicts.size();
  endfunction

  task report(string what);
    errors++;
    $display("MISMATCH result %0d: %s", results_seen, what);
  endtask

  task check_result(out_t got);
    out_t want;
    if (owed_verdicts.size() == 0) begin
      report("result with no request outstanding");
    end else begin
      want = owed_verdicts.pop_front();
      if (got.feed !== want.feed)
        report($sformatf("feed got %0b want %0b", got.feed, want.feed));
      if (got.panic_reason !== want.panic_reason)
        report($sformatf("panic_reason got %0d want %0d",
                         got.panic_reason, want.panic_reason));
    end
    results_seen++;
  endtask
endclass

module task_alive_watchdog_supervisor_core_test;

  localparam int TASK_TOTAL  = 8;
  localparam int PHASE_ITEMS = 225;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  supervisor_scoreboard #(TASK_TOTAL) sb;

  logic [31:0] current_tick;
  logic [31:0] cur_limit;
  logic [31:0] cur_period;
  bit          calm;
  bit          hold_request;
  int          sent;
  int          cycle_count;
  bit          result_fire;
  out_t        result_seen;

  task_alive_watchdog_supervisor_core #(
    .TASK_COUNT(TASK_TOTAL)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("task_alive_watchdog_supervisor_core verification failed");
    $finish;
  end

  // Sample results mid-cycle, score them at the edge that takes them
  always @(negedge clk) begin
    result_fire = rst_n && out_valid && !out_stall;
    result_seen = out_data;
  end

  always @(posedge clk) begin
    if (result_fire) sb.check_result(result_seen);
  end

  // Result side stalls, with one long hold-off on request
  initial begin
    int  n;
    bit  fire;
    out_stall <= 1'b0;
    wait (rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        n = HOLD_CYCLES;
      end else begin
        n = calm ? 0 : $urandom_range(15, 0);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do begin
        @(negedge clk);
        fire = out_valid && !out_stall;
        @(posedge clk);
      end while (!fire);
    end
  end

  function automatic in_t random_request();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(in_t)-1:0];
  endfunction

  // Harmless filler: stray ids, reserved kind, panic with no reason
  function automatic in_t noise_request();
    in_t req;
    req = random_request();
    case ($urandom_range(2, 0))
      0: begin
        req.req_type = REQ_TASK_ALIVE;
        if ($urandom_range(1, 0)) req.task_id = 8'($urandom_range(255, TASK_TOTAL));
      end
      1: req.req_type = REQ_RESERVED;
      default: begin
        req.req_type   = REQ_PANIC;
        req.panic_code = REASON_NONE;
      end
    endcase
    return req;
  endfunction

  // Time step to the next check; never beyond the loop limit
  function automatic logic [31:0] pick_step();
    logic [31:0] s;
    case ($urandom_range(5, 0))
      0: s = cur_limit;
      1: s = 32'd0;
      2: s = $urandom_range(cur_limit, 0);
      3: s = $urandom_range((cur_limit < 32'd64) ? cur_limit : 32'd64, 0);
      4: s = sb.last_feed + cur_period - current_tick;
      default: s = sb.last_feed + cur_period - current_tick - 32'd1;
    endcase
    if (s > cur_limit) s = cur_limit;
    return s;
  endfunction

  task automatic send_request(input in_t req);
    int gap;
    bit fire;
    gap = calm ? 0 : $urandom_range(15, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do begin
      @(negedge clk);
      fire = in_valid && !in_stall;
      if (fire) sb.note_request(in_data);
      @(posedge clk);
    end while (!fire);
    sent++;
  endtask

  // Wait until every verdict is back and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.verdicts_due() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
    bit fire;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      fire = cfg_valid && cfg_ready;
      @(posedge clk);
    end while (!fire);
    sb.set_register(idx, val);
  endtask

  task automatic configure(input logic [31:0] limit, input logic [31:0] period,
                           input logic enable);
    drain();
    write_register(CFG_LOOP_LIMIT, limit);
    write_register(CFG_FEED_PERIOD, period);
    write_register(CFG_WDG_ENABLE, {31'd0, enable});
    cfg_valid <= 1'b0;
    cur_limit  = limit;
    cur_period = period;
  endtask

  // Every task reports in random order, with filler, then a loop check.
  // A task left out (skip_id) makes the check miss.
  task automatic run_round(input int skip_id, input logic [31:0] step);
    int  order[TASK_TOTAL];
    int  j;
    int  t;
    in_t req;
    for (int i = 0; i < TASK_TOTAL; i++) order[i] = i;
    for (int i = TASK_TOTAL - 1; i > 0; i--) begin
      j = $urandom_range(i, 0);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < TASK_TOTAL; i++) begin
      if (skip_id < 0 && $urandom_range(3, 0) == 0) send_request(noise_request());
      if (order[i] != skip_id) begin
        req = random_request();
        req.req_type = REQ_TASK_ALIVE;
        req.task_id  = 8'(order[i]);
        send_request(req);
      end
    end
    req = random_request();
    req.req_type = REQ_LOOP_CHECK;
    req.tick_ms  = current_tick + step;
    current_tick = req.tick_ms;
    send_request(req);
  endtask

  initial begin
    in_t req;
    int  target;
    sb           = new();
    current_tick = '0;
    cur_limit    = LOOP_LIMIT_RST;
    cur_period   = FEED_PERIOD_RST;
    calm         = 1'b0;
    hold_request = 1'b0;
    sent         = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reserved kind, empty panic, stray ids, then checks at
    // time zero and with the watchdog still disabled
    req = random_request();
    req.req_type = REQ_RESERVED;
    send_request(req);
    req = random_request();
    req.req_type   = REQ_PANIC;
    req.panic_code = REASON_NONE;
    send_request(req);
    req = random_request();
    req.req_type = REQ_TASK_ALIVE;
    req.task_id  = 8'(TASK_TOTAL);
    send_request(req);
    req.task_id  = 8'hFF;
    send_request(req);
    run_round(-1, 32'd0);
    run_round(-1, 32'd100);

    // Random rounds under a range of settings, extremes included
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: configure(32'd100, 32'd100, 1'b1);
        1: configure(32'd0, 32'd0, 1'b1);
        2: configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        3: configure(32'hFFFF_FFFF, 32'd0, 1'b0);
        4: configure($urandom, $urandom, 1'b1);
        5: configure(32'd1000, 32'd37, 1'b1);
        default: configure($urandom_range(65535, 0), $urandom_range(65535, 0),
                           1'($urandom_range(1, 0)));
      endcase
      calm = (p == 1 || p == 4);
      // long result hold-off so the pipeline backs up into the input
      if (p == 1) hold_request = 1'b1;
      target = sent + PHASE_ITEMS;
      while (sent < target) run_round(-1, pick_step());
    end

    // Close with one latched panic of a random kind, then anything at all
    configure($urandom_range(1000, 1), $urandom_range(200, 0), 1'b1);
    calm = 1'b0;
    run_round(-1, (current_tick == 32'hFFFF_FFFF) ? 32'd2 : 32'd1);
    case ($urandom_range(2, 0))
      0: run_round(-1, cur_limit + 32'd1 + $urandom_range(50, 0));
      1: run_round($urandom_range(TASK_TOTAL - 1, 0), pick_step());
      default: begin
        req = random_request();
        req.req_type   = REQ_PANIC;
        req.panic_code = 4'($urandom_range(15, 1));
        send_request(req);
      end
    endcase
    repeat (50) send_request(random_request());

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.verdicts_due() == 0) begin
      $display("task_alive_watchdog_supervisor_core verification clean");
    end else begin
      $display("task_alive_watchdog_supervisor_core verification failed");
    end
    $finish;
  end

endmodule
